[rtl/assert_macros.svh]
// Assertion macros used by the translator datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/tlbpat_pkg.sv]
// Shared types and constants for the paged address translator
package tlbpat_pkg;
    localparam int unsigned ADDR_W = 16;
    localparam int unsigned PAGE_W = 8;
    localparam int unsigned FRAME_W = 8;
    localparam int unsigned CNT_W = 32;
    localparam int unsigned FCNT_W = 9;
    localparam logic [FCNT_W-1:0] FRAME_COUNT_RESET = 9'd128;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PT_READ,
        ST_FREE_SCAN,
        ST_LRU_SCAN,
        ST_LRU_LAST,
        ST_EVICT,
        ST_COMMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic map_load;
        logic free_init;
        logic free_step;
        logic free_take;
        logic lru_init;
        logic lru_step;
        logic evict;
        logic commit;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic tlb_hit;
        logic mapped;
        logic free_found;
        logic free_end;
        logic lru_end;
    } status_t;
endpackage

[rtl/tlbpat_ctrl.sv]
// Sequencer for lookup, free-frame scan, LRU scan and commit
module tlbpat_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tlbpat_pkg::status_t sts,
    output logic                busy,
    output tlbpat_pkg::cmd_t    cmd
);
    tlbpat_pkg::state_t state_reg;
    tlbpat_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlbpat_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != tlbpat_pkg::ST_IDLE);
        case (state_reg)
            tlbpat_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next = tlbpat_pkg::ST_LOOKUP;
                end
            end
            tlbpat_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = tlbpat_pkg::ST_PT_READ;
            end
            tlbpat_pkg::ST_PT_READ:
            begin
                if (sts.tlb_hit)
                begin
                    state_next = tlbpat_pkg::ST_COMMIT;
                end
                else if (sts.mapped)
                begin
                    cmd.map_load = 1'b1;
                    state_next = tlbpat_pkg::ST_COMMIT;
                end
                else
                begin
                    cmd.free_init = 1'b1;
                    state_next = tlbpat_pkg::ST_FREE_SCAN;
                end
            end
            tlbpat_pkg::ST_FREE_SCAN:
            begin
                if (sts.free_found)
                begin
                    cmd.free_take = 1'b1;
                    state_next = tlbpat_pkg::ST_COMMIT;
                end
                else if (sts.free_end)
                begin
                    cmd.lru_init = 1'b1;
                    state_next = tlbpat_pkg::ST_LRU_SCAN;
                end
                else
                begin
                    cmd.free_step = 1'b1;
                end
            end
            tlbpat_pkg::ST_LRU_SCAN:
            begin
                cmd.lru_step = 1'b1;
                if (sts.lru_end)
                begin
                    state_next = tlbpat_pkg::ST_LRU_LAST;
                end
            end
            tlbpat_pkg::ST_LRU_LAST:
            begin
                cmd.lru_step = 1'b1;
                state_next = tlbpat_pkg::ST_EVICT;
            end
            tlbpat_pkg::ST_EVICT:
            begin
                cmd.evict = 1'b1;
                state_next = tlbpat_pkg::ST_COMMIT;
            end
            tlbpat_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = tlbpat_pkg::ST_DONE;
            end
            tlbpat_pkg::ST_DONE:
            begin
                cmd.emit = 1'b1;
                state_next = tlbpat_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tlbpat_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

[rtl/tlbpat_dp.sv]
// TLB, page table, stamp memory, frame bitmap, scans and counters
`include "assert_macros.svh"
module tlbpat_dp
#(
    parameter int unsigned TLB_ENTRIES = 16,
    parameter int unsigned PAGE_COUNT = 256,
    parameter int unsigned MAX_FRAMES = 256
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tlbpat_pkg::cmd_t                      cmd,
    input  logic [tlbpat_pkg::ADDR_W-1:0]         virtual_address,
    input  logic [tlbpat_pkg::FCNT_W-1:0]         frame_count,
    output tlbpat_pkg::status_t                   sts,
    output logic                                  done,
    output logic [tlbpat_pkg::ADDR_W-1:0]         physical_address,
    output logic                                  tlb_hit,
    output logic                                  map_fault,
    output logic                                  evicted,
    output logic [tlbpat_pkg::PAGE_W-1:0]         victim_page,
    output logic [tlbpat_pkg::CNT_W-1:0]          access_total,
    output logic [tlbpat_pkg::CNT_W-1:0]          fault_total,
    output logic [tlbpat_pkg::CNT_W-1:0]          hit_total
);
    localparam int unsigned TI_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int unsigned PI_W = $clog2(PAGE_COUNT);
    localparam int unsigned FI_W = $clog2(MAX_FRAMES);
    localparam int unsigned PC_W = PI_W + 1;
    localparam int unsigned FC_W = FI_W + 1;
    localparam int unsigned PW = tlbpat_pkg::PAGE_W;
    localparam int unsigned FW = tlbpat_pkg::FRAME_W;
    localparam int unsigned CW = tlbpat_pkg::CNT_W;
    localparam logic [TI_W-1:0] TLB_LAST = TI_W'(TLB_ENTRIES - 1);
    localparam logic [PC_W-1:0] PAGE_CNT = PC_W'(PAGE_COUNT);
    localparam logic [FC_W-1:0] FRAME_MAX = FC_W'(MAX_FRAMES);
    localparam logic [CW-1:0] CNT_MAX = '1;

    logic [PW-1:0] tag_reg [TLB_ENTRIES];
    logic [FW-1:0] tfr_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tvalid_reg;
    logic [TI_W-1:0] fill_reg;
    logic [FW-1:0] pmap_mem [PAGE_COUNT];
    logic [CW-1:0] stamp_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] mapped_reg;
    logic [MAX_FRAMES-1:0] inuse_reg;
    logic [CW-1:0] acc_reg;
    logic [CW-1:0] flt_reg;
    logic [CW-1:0] hit_reg;

    logic [PI_W-1:0] page_reg;
    logic [7:0] offset_reg;
    logic tlbhit_reg;
    logic fault_reg;
    logic ev_reg;
    logic [FW-1:0] frame_reg;
    logic [FW-1:0] pmap_rd_reg;
    logic [FC_W-1:0] limit_reg;
    logic [FC_W-1:0] fidx_reg;
    logic [PC_W-1:0] pidx_reg;
    logic [PI_W-1:0] lru_page_reg;
    logic lru_rd_valid_reg;
    logic [CW-1:0] stamp_rd_reg;
    logic [FW-1:0] lru_frame_rd_reg;
    logic any_reg;
    logic [CW-1:0] best_reg;
    logic [PI_W-1:0] victim_reg;
    logic [FW-1:0] victim_frame_reg;
    logic done_reg;

    logic [PW-1:0] out_victim_reg;
    logic [FW-1:0] out_frame_reg;
    logic out_hit_reg;
    logic out_fault_reg;
    logic out_ev_reg;

    logic match_any;
    logic [FW-1:0] match_frame;
    logic [FC_W-1:0] limit_calc;
    logic [FI_W-1:0] fidx_cur;
    logic [PI_W-1:0] rd_page;

    always_comb
    begin
        match_any = 1'b0;
        match_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            if (tvalid_reg[i] && tag_reg[i] == PW'(page_reg))
            begin
                match_any = 1'b1;
                match_frame = tfr_reg[i];
            end
        end
    end

    always_comb
    begin
        if (frame_count == '0)
        begin
            limit_calc = FC_W'(1);
        end
        else if ({1'b0, frame_count} > (tlbpat_pkg::FCNT_W + 1)'(MAX_FRAMES))
        begin
            limit_calc = FRAME_MAX;
        end
        else
        begin
            limit_calc = FC_W'(frame_count);
        end
    end

    assign fidx_cur = fidx_reg[FI_W-1:0];
    assign rd_page = cmd.lru_step ? pidx_reg[PI_W-1:0] : page_reg;

    always_ff @(posedge clk)
    begin
        pmap_rd_reg <= pmap_mem[rd_page];
        stamp_rd_reg <= stamp_mem[rd_page];
        lru_page_reg <= rd_page;
        if (cmd.commit && !tlbhit_reg && fault_reg)
        begin
            pmap_mem[page_reg] <= frame_reg;
        end
        if (cmd.commit)
        begin
            stamp_mem[page_reg] <= acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= '0;
            fill_reg <= '0;
            mapped_reg <= '0;
            inuse_reg <= '0;
            acc_reg <= '0;
            flt_reg <= '0;
            hit_reg <= '0;
            done_reg <= 1'b0;
            lru_rd_valid_reg <= 1'b0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                tag_reg[i] <= '0;
                tfr_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= cmd.emit;
            lru_rd_valid_reg <= cmd.lru_step && (pidx_reg < PAGE_CNT);
            if (cmd.evict && any_reg)
            begin
                mapped_reg[victim_reg] <= 1'b0;
                inuse_reg[victim_frame_reg[FI_W-1:0]] <= 1'b0;
                for (int i = 0; i < TLB_ENTRIES; i++)
                begin
                    if (tag_reg[i] == PW'(victim_reg))
                    begin
                        tvalid_reg[i] <= 1'b0;
                    end
                end
            end
            if (cmd.commit)
            begin
                if (!tlbhit_reg)
                begin
                    tag_reg[fill_reg] <= PW'(page_reg);
                    tfr_reg[fill_reg] <= frame_reg;
                    tvalid_reg[fill_reg] <= 1'b1;
                    fill_reg <= (fill_reg == TLB_LAST) ? '0 : fill_reg + 1'b1;
                    if (fault_reg)
                    begin
                        mapped_reg[page_reg] <= 1'b1;
                        inuse_reg[frame_reg[FI_W-1:0]] <= 1'b1;
                    end
                end
                if (acc_reg != CNT_MAX)
                begin
                    acc_reg <= acc_reg + 1'b1;
                end
                if (fault_reg && flt_reg != CNT_MAX)
                begin
                    flt_reg <= flt_reg + 1'b1;
                end
                if (tlbhit_reg && hit_reg != CNT_MAX)
                begin
                    hit_reg <= hit_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lru_frame_rd_reg <= pmap_mem[rd_page];
        if (cmd.capture)
        begin
            page_reg <= PI_W'(virtual_address[15:8]);
            offset_reg <= virtual_address[7:0];
            tlbhit_reg <= 1'b0;
            fault_reg <= 1'b0;
            ev_reg <= 1'b0;
            frame_reg <= '0;
            victim_reg <= '0;
        end
        if (cmd.lookup)
        begin
            tlbhit_reg <= match_any;
            frame_reg <= match_frame;
            limit_reg <= limit_calc;
        end
        if (cmd.map_load)
        begin
            frame_reg <= pmap_rd_reg;
        end
        if (cmd.free_init)
        begin
            fault_reg <= 1'b1;
            fidx_reg <= '0;
        end
        if (cmd.free_step)
        begin
            fidx_reg <= fidx_reg + 1'b1;
        end
        if (cmd.free_take)
        begin
            frame_reg <= FW'(fidx_cur);
        end
        if (cmd.lru_init)
        begin
            pidx_reg <= '0;
            any_reg <= 1'b0;
            best_reg <= '0;
        end
        if (cmd.lru_step)
        begin
            pidx_reg <= pidx_reg + 1'b1;
        end
        if (lru_rd_valid_reg && mapped_reg[lru_page_reg]
            && (!any_reg || stamp_rd_reg < best_reg))
        begin
            any_reg <= 1'b1;
            best_reg <= stamp_rd_reg;
            victim_reg <= lru_page_reg;
            victim_frame_reg <= lru_frame_rd_reg;
        end
        if (cmd.evict)
        begin
            ev_reg <= any_reg;
            frame_reg <= any_reg ? victim_frame_reg : '0;
            if (!any_reg)
            begin
                victim_reg <= '0;
            end
        end
        if (cmd.emit)
        begin
            out_frame_reg <= frame_reg;
            out_hit_reg <= tlbhit_reg;
            out_fault_reg <= fault_reg;
            out_ev_reg <= ev_reg;
            out_victim_reg <= ev_reg ? PW'(victim_reg) : '0;
        end
    end

    // status is valid in the state after lookup; free scan flags use the bitmap
    assign sts.tlb_hit = tlbhit_reg;
    assign sts.mapped = mapped_reg[page_reg];
    assign sts.free_end = (fidx_reg >= limit_reg);
    assign sts.free_found = !sts.free_end && !inuse_reg[fidx_cur] && fault_reg;
    assign sts.lru_end = (pidx_reg == PAGE_CNT - 1'b1);

    assign done = done_reg;
    assign physical_address = {out_frame_reg, offset_reg};
    assign tlb_hit = out_hit_reg;
    assign map_fault = out_fault_reg;
    assign evicted = out_ev_reg;
    assign victim_page = out_victim_reg;
    assign access_total = acc_reg;
    assign fault_total = flt_reg;
    assign hit_total = hit_reg;

    `CHK_IMPL(a_hit_nofault, clk, rst_n, done, !(tlb_hit && map_fault), "hit with fault")
    `CHK_IMPL(a_ev_fault, clk, rst_n, done && evicted, map_fault, "evict without fault")
    `CHK_NEXT(a_cnt_mono, clk, rst_n, done, $stable(access_total), "count moved after done")
endmodule

[rtl/tlb_paged_address_translator_top.sv]
// Top level of the paged address translator
// A TLB hit or mapped page goes lookup, page-table read, commit, done; a fault first
// scans for a free frame and, if none is free below the frame limit, scans LRU stamps
// and evicts. One transaction at a time; start is taken again in the result cycle.
// The free-frame scan and the LRU stamp scan (one entry a cycle) set the worst case.
// Reset clears TLB valid bits, bitmaps and counters; frame_count resets to 128.
module tlb_paged_address_translator_top
#(
    parameter int unsigned TLB_ENTRIES = 16,
    parameter int unsigned PAGE_COUNT = 256,
    parameter int unsigned MAX_FRAMES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] virtual_address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    output logic        result_valid,
    output logic [15:0] physical_address,
    output logic        tlb_hit,
    output logic        map_fault,
    output logic        evicted,
    output logic [7:0]  victim_page,
    output logic [31:0] access_total,
    output logic [31:0] fault_total,
    output logic [31:0] hit_total
);
    tlbpat_pkg::cmd_t cmd;
    tlbpat_pkg::status_t sts;
    logic [tlbpat_pkg::FCNT_W-1:0] fcount_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg <= tlbpat_pkg::FRAME_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            fcount_reg <= cfg_data;
        end
    end

    tlbpat_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    tlbpat_dp
    #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_COUNT  (PAGE_COUNT),
        .MAX_FRAMES  (MAX_FRAMES)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .virtual_address  (virtual_address),
        .frame_count      (fcount_reg),
        .sts              (sts),
        .done             (result_valid),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .map_fault        (map_fault),
        .evicted          (evicted),
        .victim_page      (victim_page),
        .access_total     (access_total),
        .fault_total      (fault_total),
        .hit_total        (hit_total)
    );
endmodule

[verif/tlb_paged_address_translator_top_tb.sv]
// Testbench for the paged address translator: directed table, then random traffic
module tlb_paged_address_translator_top_tb;
    localparam int TLB_N = 16;
    localparam int PAGE_N = 256;
    localparam int FRAME_N = 256;
    localparam int CYCLE_LIMIT = 3000000;

    typedef enum logic [1:0] {ROW_ACCESS, ROW_CHECKED, ROW_FRAMES} row_kind_t;

    typedef struct packed {
        logic [15:0] physical_address;
        logic        tlb_hit;
        logic        map_fault;
        logic        evicted;
        logic [7:0]  victim_page;
        logic [31:0] access_total;
        logic [31:0] fault_total;
        logic [31:0] hit_total;
    } xlat_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] value;
        logic [15:0] physical_address;
        logic        tlb_hit;
        logic        map_fault;
        logic        evicted;
        logic [7:0]  victim_page;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] virtual_address;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    logic        result_valid;
    logic [15:0] physical_address;
    logic        tlb_hit;
    logic        map_fault;
    logic        evicted;
    logic [7:0]  victim_page;
    logic [31:0] access_total;
    logic [31:0] fault_total;
    logic [31:0] hit_total;

    tlb_paged_address_translator_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .virtual_address(virtual_address),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .physical_address(physical_address),
        .tlb_hit(tlb_hit),
        .map_fault(map_fault),
        .evicted(evicted),
        .victim_page(victim_page),
        .access_total(access_total),
        .fault_total(fault_total),
        .hit_total(hit_total)
    );

    // translator shadow state
    logic [7:0]  tlb_tag [TLB_N];
    logic [7:0]  tlb_frame [TLB_N];
    logic        tlb_valid [TLB_N];
    int          tlb_next;
    logic [7:0]  page_frame [PAGE_N];
    logic        page_present [PAGE_N];
    logic [31:0] page_stamp [PAGE_N];
    logic        frame_busy [FRAME_N];
    logic [31:0] n_access;
    logic [31:0] n_fault;
    logic [31:0] n_hit;
    logic [8:0]  frame_limit;

    xlat_t pending_xlat [$];
    int    error_count = 0;
    int    cycle_count = 0;
    row_t  directed [$];

    always #1 clk = ~clk;

    function automatic logic [31:0] sat_bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic xlat_t translate(logic [15:0] va);
        xlat_t r;
        logic [7:0]  page;
        logic [7:0]  frame;
        logic [31:0] stamp;
        logic        hit;
        logic        fault;
        logic        ev;
        logic        found;
        logic        any;
        logic [31:0] oldest;
        logic [7:0]  victim;
        int          limit;
        page = va[15:8];
        frame = 8'd0;
        stamp = n_access;
        hit = 1'b0;
        fault = 1'b0;
        ev = 1'b0;
        victim = 8'd0;
        for (int i = 0; i < TLB_N; i++)
        begin
            if (tlb_valid[i] && tlb_tag[i] == page)
            begin
                hit = 1'b1;
                frame = tlb_frame[i];
            end
        end
        if (!hit)
        begin
            if (page_present[page])
            begin
                frame = page_frame[page];
            end
            else
            begin
                fault = 1'b1;
                found = 1'b0;
                limit = int'(frame_limit);
                if (limit == 0) limit = 1;
                if (limit > FRAME_N) limit = FRAME_N;
                for (int i = 0; i < limit; i++)
                begin
                    if (!found && !frame_busy[i])
                    begin
                        frame = i[7:0];
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    any = 1'b0;
                    oldest = 32'd0;
                    for (int i = 0; i < PAGE_N; i++)
                    begin
                        if (page_present[i] && (!any || page_stamp[i] < oldest))
                        begin
                            any = 1'b1;
                            oldest = page_stamp[i];
                            victim = i[7:0];
                        end
                    end
                    if (any)
                    begin
                        ev = 1'b1;
                        frame = page_frame[victim];
                        page_present[victim] = 1'b0;
                        frame_busy[frame] = 1'b0;
                        for (int i = 0; i < TLB_N; i++)
                            if (tlb_tag[i] == victim) tlb_valid[i] = 1'b0;
                    end
                    else
                    begin
                        frame = 8'd0;
                        victim = 8'd0;
                    end
                end
                page_frame[page] = frame;
                page_present[page] = 1'b1;
                frame_busy[frame] = 1'b1;
            end
            tlb_tag[tlb_next] = page;
            tlb_frame[tlb_next] = frame;
            tlb_valid[tlb_next] = 1'b1;
            tlb_next = (tlb_next + 1) % TLB_N;
        end
        page_stamp[page] = stamp;
        n_access = sat_bump(n_access);
        if (fault) n_fault = sat_bump(n_fault);
        if (hit) n_hit = sat_bump(n_hit);
        r.physical_address = {frame, va[7:0]};
        r.tlb_hit = hit;
        r.map_fault = fault;
        r.evicted = ev;
        r.victim_page = ev ? victim : 8'd0;
        r.access_total = n_access;
        r.fault_total = n_fault;
        r.hit_total = n_hit;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        error_count++;
    endtask

    // check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        xlat_t w;
        if (rst_n && result_valid)
        begin
            if (pending_xlat.size() == 0)
            begin
                report("unexpected result", 32'd1, 32'd0);
            end
            else
            begin
                w = pending_xlat.pop_front();
                if (physical_address !== w.physical_address)
                    report("physical_address", 32'(physical_address),
                           32'(w.physical_address));
                if (tlb_hit !== w.tlb_hit) report("tlb_hit", 32'(tlb_hit), 32'(w.tlb_hit));
                if (map_fault !== w.map_fault)
                    report("map_fault", 32'(map_fault), 32'(w.map_fault));
                if (evicted !== w.evicted) report("evicted", 32'(evicted), 32'(w.evicted));
                if (victim_page !== w.victim_page)
                    report("victim_page", 32'(victim_page), 32'(w.victim_page));
                if (access_total !== w.access_total)
                    report("access_total", access_total, w.access_total);
                if (fault_total !== w.fault_total)
                    report("fault_total", fault_total, w.fault_total);
                if (hit_total !== w.hit_total) report("hit_total", hit_total, w.hit_total);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tlb_paged_address_translator_top_tb: FAIL");
            $finish;
        end
    end

    // hold start high until the transaction is taken; start stays high afterwards
    task automatic issue(input logic [15:0] va, input logic typed, input row_t row);
        xlat_t p;
        start <= 1'b1;
        virtual_address <= va;
        do @(posedge clk); while (busy);
        p = translate(va);
        if (typed)
        begin
            p.physical_address = row.physical_address;
            p.tlb_hit = row.tlb_hit;
            p.map_fault = row.map_fault;
            p.evicted = row.evicted;
            p.victim_page = row.victim_page;
        end
        pending_xlat.push_back(p);
    endtask

    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic set_frames(input logic [8:0] value);
        @(posedge clk);
        start <= 1'b0;
        while (pending_xlat.size() != 0 || busy) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        frame_limit = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input row_kind_t k, input logic [15:0] v, input logic [15:0] pa,
                           input logic h, input logic f, input logic e, input logic [7:0] vp);
        row_t r;
        r.kind = k;
        r.value = v;
        r.physical_address = pa;
        r.tlb_hit = h;
        r.map_fault = f;
        r.evicted = e;
        r.victim_page = vp;
        directed.push_back(r);
    endtask

    function automatic logic [15:0] pick_address(int hot_pages);
        logic [7:0] page;
        if ($urandom_range(0, 9) < 8)
            page = 8'($urandom_range(0, hot_pages - 1));
        else
            page = 8'($urandom_range(0, 255));
        return {page, 8'($urandom_range(0, 255))};
    endfunction

    initial
    begin
        logic [8:0] settings [10];
        int hot;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        virtual_address = 16'd0;
        cfg_valid = 1'b0;
        cfg_data = 9'd0;
        for (int i = 0; i < TLB_N; i++)
        begin
            tlb_tag[i] = 8'd0;
            tlb_frame[i] = 8'd0;
            tlb_valid[i] = 1'b0;
        end
        for (int i = 0; i < PAGE_N; i++)
        begin
            page_frame[i] = 8'd0;
            page_present[i] = 1'b0;
            page_stamp[i] = 32'd0;
            frame_busy[i] = 1'b0;
        end
        tlb_next = 0;
        n_access = 32'd0;
        n_fault = 32'd0;
        n_hit = 32'd0;
        frame_limit = tlbpat_pkg::FRAME_COUNT_RESET;

        add_row(ROW_CHECKED, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 8'h00);
        add_row(ROW_CHECKED, 16'h00FF, 16'h00FF, 1'b1, 1'b0, 1'b0, 8'h00);
        add_row(ROW_CHECKED, 16'hFFFF, 16'h01FF, 1'b0, 1'b1, 1'b0, 8'h00);
        add_row(ROW_CHECKED, 16'hFF00, 16'h0100, 1'b1, 1'b0, 1'b0, 8'h00);
        add_row(ROW_FRAMES, 16'd1, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_row(ROW_CHECKED, 16'h1234, 16'h0034, 1'b0, 1'b1, 1'b1, 8'h00);
        add_row(ROW_CHECKED, 16'h0001, 16'h0101, 1'b0, 1'b1, 1'b1, 8'hFF);
        add_row(ROW_CHECKED, 16'h12AB, 16'h00AB, 1'b1, 1'b0, 1'b0, 8'h00);
        add_row(ROW_FRAMES, 16'd0, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_row(ROW_ACCESS, 16'h5555, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_row(ROW_ACCESS, 16'hAAAA, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_row(ROW_ACCESS, 16'h0180, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_row(ROW_FRAMES, 16'd511, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_row(ROW_ACCESS, 16'h8001, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_row(ROW_ACCESS, 16'h7FFE, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_row(ROW_ACCESS, 16'h5555, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_row(ROW_FRAMES, 16'd256, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_row(ROW_ACCESS, 16'h0001, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);
        add_row(ROW_ACCESS, 16'hAAAA, 16'h0, 1'b0, 1'b0, 1'b0, 8'h00);

        settings = '{9'd2, 9'd4, 9'd8, 9'd16, 9'd1, 9'd128, 9'd256, 9'd0, 9'd511, 9'd3};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_FRAMES)
                set_frames(directed[i].value[8:0]);
            else
            begin
                issue(directed[i].value, directed[i].kind == ROW_CHECKED, directed[i]);
                pause_sender();
            end
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 9)
                set_frames(9'($urandom_range(0, 511)));
            else
                set_frames(settings[ph]);
            hot = (ph % 3 == 0) ? 24 : ((ph % 3 == 1) ? 6 : 64);
            for (int k = 0; k < 85; k++)
            begin
                issue(pick_address(hot), 1'b0, directed[0]);
                pause_sender();
            end
        end

        @(posedge clk);
        start <= 1'b0;
        while (pending_xlat.size() != 0) @(posedge clk);
        repeat (800) @(posedge clk);
        if (error_count == 0)
            $display("tlb_paged_address_translator_top_tb: PASS");
        else
            $display("tlb_paged_address_translator_top_tb: FAIL");
        $finish;
    end
endmodule
